// ----- rtl/aes_cbc_cipher_macros.svh -----
// Assertion macros shared by the checker.
`ifndef AES_CBC_CIPHER_MACROS_SVH
`define AES_CBC_CIPHER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ACC_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ACC_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);
`endif

// ----- rtl/acc_pkg.sv -----
// Package with AES tables, round helpers and codes for the CBC cipher.
package acc_pkg;

  localparam int KeyScheduleWords = 60;
  localparam int RkAw = 6;

  localparam logic [2:0] RegKey0 = 3'd0;
  localparam logic [2:0] RegKey1 = 3'd1;
  localparam logic [2:0] RegKey2 = 3'd2;
  localparam logic [2:0] RegKey3 = 3'd3;
  localparam logic [2:0] RegIvHigh = 3'd4;
  localparam logic [2:0] RegIvLow = 3'd5;
  localparam logic [2:0] RegKeyLength = 3'd6;
  localparam logic [2:0] RegDirection = 3'd7;

  typedef struct packed {
    logic        we;
    logic [RkAw-1:0] waddr;
    logic [31:0] wdata;
    logic [RkAw-1:0] raddr;
  } rk_req_t;

  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] fwd_sub(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    fwd_sub = t[x];
  endfunction

  function automatic logic [7:0] inv_sub(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sub = t[x];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {fwd_sub(w[31:24]), fwd_sub(w[23:16]), fwd_sub(w[15:8]), fwd_sub(w[7:0])};
  endfunction

  // Byte k of the state sits at bits [127-8k -: 8].
  function automatic logic [7:0] sb(input logic [127:0] s, input int k);
    sb = s[127-8*k -: 8];
  endfunction

  function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic final_rnd);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3, x;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[127-8*(r+4*c) -: 8] = fwd_sub(sb(s, r + 4*((c + r) % 4)));
    m = t;
    for (int c = 0; c < 4; c++) begin
      a0 = sb(t, 4*c); a1 = sb(t, 4*c+1); a2 = sb(t, 4*c+2); a3 = sb(t, 4*c+3);
      x = a0 ^ a1 ^ a2 ^ a3;
      m[127-8*(4*c) -: 8]   = a0 ^ x ^ xt(a0 ^ a1);
      m[127-8*(4*c+1) -: 8] = a1 ^ x ^ xt(a1 ^ a2);
      m[127-8*(4*c+2) -: 8] = a2 ^ x ^ xt(a2 ^ a3);
      m[127-8*(4*c+3) -: 8] = a3 ^ x ^ xt(a3 ^ a0);
    end
    fwd_round = final_rnd ? t : m;
  endfunction

  function automatic logic [127:0] inv_shsub(input logic [127:0] s);
    logic [127:0] t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[127-8*(r+4*c) -: 8] = inv_sub(sb(s, r + 4*((c + 4 - r) % 4)));
    inv_shsub = t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] m;
    logic [7:0] a [4];
    logic [7:0] a2 [4];
    logic [7:0] a4 [4];
    logic [7:0] a8 [4];
    logic [7:0] e [4];
    logic [7:0] b [4];
    logic [7:0] d [4];
    logic [7:0] n [4];
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        a[i] = sb(s, 4*c+i);
        a2[i] = xt(a[i]); a4[i] = xt(a2[i]); a8[i] = xt(a4[i]);
        n[i] = a8[i] ^ a[i];
        b[i] = n[i] ^ a2[i];
        d[i] = n[i] ^ a4[i];
        e[i] = a8[i] ^ a4[i] ^ a2[i];
      end
      for (int i = 0; i < 4; i++)
        m[127-8*(4*c+i) -: 8] = e[i] ^ b[(i+1)%4] ^ d[(i+2)%4] ^ n[(i+3)%4];
    end
    inv_mix = m;
  endfunction

endpackage

// ----- rtl/acc_rk_ram.sv -----
// Round-key store: one write port, one registered read port.
module acc_rk_ram import acc_pkg::*; (
  input  logic        clk,
  input  rk_req_t     req,
  output logic [31:0] rdata
);
  logic [31:0] mem [KeyScheduleWords];

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    rdata <= mem[req.raddr];
  end
endmodule

// ----- rtl/acc_core.sv -----
// Sequencer: key expansion into the round-key store and iterative rounds.
module acc_core import acc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [255:0] key,
  input  logic [1:0]   klen,
  input  logic         dir,
  input  logic         sched_clear,
  input  logic         start,
  input  logic [127:0] din,
  output logic         done,
  output logic [127:0] dout,
  output rk_req_t      rk_req,
  input  logic [31:0]  rk_rdata
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExp  = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StRnd  = 3'd3;

  logic [2:0] state;
  logic       sched_ready;
  logic [5:0] idx;
  logic [5:0] ridx;
  logic [1:0] col;
  logic [3:0] rnd;
  logic [127:0] st;
  logic [95:0]  kacc;
  logic [31:0]  hist [8];
  logic [7:0]   rc;
  logic [2:0]   kpos;
  logic [3:0]   nk;
  logic [3:0]   nr;
  logic [5:0]   total;
  logic [31:0]  tw;
  logic [31:0]  newk;
  logic [127:0] rkey;

  always_comb begin
    unique case (klen)
      2'd0:    nk = 4'd4;
      2'd1:    nk = 4'd6;
      default: nk = 4'd8;
    endcase
    nr = nk + 4'd6;
    total = {nr, 2'b00} + 6'd4;
  end

  // Next schedule word from a window of the last nk words.
  always_comb begin
    tw = hist[3'(nk - 4'd1)];
    if (kpos == 3'd0)
      tw = sub_word({tw[23:0], tw[31:24]}) ^ {rc, 24'h0};
    else if (nk == 4'd8 && kpos == 3'd4)
      tw = sub_word(tw);
    newk = hist[3'd0] ^ tw;
    if (idx < {2'b00, nk}) newk = key[255 - 32*idx -: 32];
  end

  assign rkey = {kacc, rk_rdata};

  always_comb begin
    rk_req = '0;
    rk_req.raddr = ridx;
    if (state == StExp) begin
      rk_req.we = 1'b1;
      rk_req.waddr = idx;
      rk_req.wdata = newk;
    end
  end

  // The last round finishes on the last key word (col 3) of round nr; done is registered.
  always_ff @(posedge clk) begin
    done <= !rst && state == StRnd && col == 2'd3 && rnd == nr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      sched_ready <= 1'b0;
    end else begin
      if (sched_clear) sched_ready <= 1'b0;
      unique case (state)
        StIdle: if (start) begin
          st <= din;
          idx <= 6'd0;
          kpos <= 3'd0;
          rc <= 8'h01;
          state <= sched_ready ? StLoad : StExp;
          ridx <= dir ? {nr, 2'b00} : 6'd0;
          col <= 2'd0;
          rnd <= 4'd0;
        end
        StExp: begin
          // hist[0] is the oldest of the last nk words.
          for (int i = 0; i < 7; i++)
            if (4'(i) < nk - 4'd1) hist[i] <= hist[i+1];
          hist[3'(nk - 4'd1)] <= newk;
          if (idx >= {2'b00, nk} && kpos == 3'd0) rc <= xt(rc);
          kpos <= (idx >= {2'b00, nk}) ? ((kpos + 3'd1 == nk[2:0] && nk != 4'd8) ? 3'd0 :
                  kpos + 3'd1) : 3'd0;
          idx <= idx + 6'd1;
          if (idx + 6'd1 == total) begin
            sched_ready <= 1'b1;
            state <= StLoad;
          end
        end
        StLoad: begin
          // Fetch four words of one round key; data comes back from the registered read port in the next cycle.
          ridx <= ridx + 6'd1;
          state <= StRnd;
        end
        default: begin
          kacc <= {kacc[63:0], rk_rdata};
          col <= col + 2'd1;
          if (col != 2'd3) ridx <= ridx + 6'd1;
          if (col == 2'd3) begin
            if (rnd == 4'd0) begin
              st <= st ^ rkey;
            end else if (!dir) begin
              st <= fwd_round(st, rnd == nr) ^ rkey;
            end else begin
              st <= (rnd == nr) ? (inv_shsub(st) ^ rkey) : inv_mix(inv_shsub(st) ^ rkey);
            end
            rnd <= rnd + 4'd1;
            if (rnd == nr) begin
              state <= StIdle;
            end else begin
              ridx <= dir ? ({nr - rnd - 4'd1, 2'b00}) : ({rnd + 4'd1, 2'b00});
              state <= StLoad;
            end
          end
        end
      endcase
    end
  end

  assign dout = st;
endmodule

// ----- rtl/aes_cbc_cipher.sv -----
// Top level of the AES CBC cipher: registers, chaining and handshakes.
//
// Use: write the key words, IV, key length and direction through the cfg
// channel while the block is idle; any write reloads the chain from the IV,
// and a key or key-length write forces a new key expansion.
// Blocks enter on the in channel (block_high, block_low, last_block) and the
// transformed block leaves on the out channel with result_last copied.
// One block is in flight at a time: in_ready is high only while no block is
// being worked on and the result register is empty.
// Each round addresses the round-key store and then streams the four key words
// out of its single read port; a block passes through Nr+1 such rounds (Nr is
// 10, 12 or 14), and before the first block after a key change the key
// expansion writes 4*(Nr+1) schedule words, one schedule word a cycle.
// After reset the key, IV and chain are zero and the schedule is marked
// stale. A stalled receiver holds the result in the output register;
// no new block is taken until that result transfers.
module aes_cbc_cipher import acc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic        last_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_high,
  output logic [63:0] result_low,
  output logic        result_last
);
  logic [255:0] key;
  logic [127:0] iv;
  logic [127:0] chain;
  logic [127:0] held_in;
  logic [1:0]   klen;
  logic         dir;
  logic         busy;
  logic         held_last;
  logic         cfg_fire;
  logic         in_fire;
  logic         done;
  logic [127:0] core_out;
  logic [127:0] din;
  logic [1:0]   klen_eff;
  rk_req_t      rk_req;
  logic [31:0]  rk_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign in_ready = !busy && !out_valid;
  assign in_fire = in_valid && in_ready;
  assign klen_eff = (klen == 2'd3) ? 2'd2 : klen;
  // Encryption whitens the plaintext with the chain before the rounds.
  assign din = dir ? {block_high, block_low} : ({block_high, block_low} ^ chain);

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0; iv <= '0; chain <= '0; klen <= 2'd0; dir <= 1'b0;
      busy <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_fire) begin
        unique case (cfg_index)
          RegKey0: key[255:192] <= cfg_data;
          RegKey1: key[191:128] <= cfg_data;
          RegKey2: key[127:64] <= cfg_data;
          RegKey3: key[63:0] <= cfg_data;
          RegIvHigh: iv[127:64] <= cfg_data;
          RegIvLow: iv[63:0] <= cfg_data;
          RegKeyLength: klen <= cfg_data[1:0];
          RegDirection: dir <= cfg_data[0];
          default: ;
        endcase
        case (cfg_index)
          RegIvHigh: chain <= {cfg_data, iv[63:0]};
          RegIvLow: chain <= {iv[127:64], cfg_data};
          default: chain <= iv;
        endcase
      end
      if (in_fire) begin
        busy <= 1'b1;
        held_in <= {block_high, block_low};
        held_last <= last_block;
      end
      if (done) begin
        busy <= 1'b0;
        out_valid <= 1'b1;
        {result_high, result_low} <= dir ? (core_out ^ chain) : core_out;
        result_last <= held_last;
        if (held_last) chain <= iv;
        else chain <= dir ? held_in : core_out;
      end
    end
  end

  acc_core u_core (
    .clk(clk), .rst(rst), .key(key), .klen(klen_eff), .dir(dir),
    .sched_clear(cfg_fire && (cfg_index <= RegKey3 || cfg_index == RegKeyLength)),
    .start(in_fire), .din(din), .done(done), .dout(core_out),
    .rk_req(rk_req), .rk_rdata(rk_rdata)
  );

  acc_rk_ram u_ram (.clk(clk), .req(rk_req), .rdata(rk_rdata));
endmodule

// ----- rtl/acc_checker.sv -----
// Port-level checker for the AES CBC cipher, bound to the top level.
`include "aes_cbc_cipher_macros.svh"
module acc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic result_last
);
  `ACC_ASSERT_IMP(a_no_in_while_out, clk, rst, out_valid, !in_ready, "input taken with result pending")
  `ACC_ASSERT_NEXT(a_busy_after_in, clk, rst, in_valid && in_ready, !in_ready, "second block overlapped")
  `ACC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result_last), "result dropped")
  `ACC_ASSERT_NEXT(a_no_early_out, clk, rst, in_valid && in_ready, !out_valid, "result too early")
endmodule

bind aes_cbc_cipher acc_checker u_acc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .result_last(result_last)
);

// ----- tb/aes_cbc_cipher_tb.sv -----
// Self-checking testbench for the AES CBC cipher: known vectors, then random CBC messages.
module aes_cbc_cipher_tb;
  import acc_pkg::*;

  // The bound covers stalls of the sender and receiver and a block with a fresh 256-bit
  // key expansion, so it is generous.
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned RandomBlocksPerPhase = 450;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } cbc_block_t;

  typedef enum logic {ROW_CFG, ROW_BLOCK} row_kind_t;

  // One row of the directed stimulus. For a block row, has_known marks a result that is
  // typed in from a published vector rather than taken from the predictor.
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  index;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
    logic        has_known;
    logic [63:0] known_hi;
    logic [63:0] known_lo;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  logic        last_block;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic        result_last;

  aes_cbc_cipher u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .block_high(block_high), .block_low(block_low), .last_block(last_block),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_high(result_high), .result_low(result_low), .result_last(result_last)
  );

  // Shadow copy of the configuration and of the cipher state.
  logic [63:0] sh_key [4];
  logic [63:0] sh_iv_high, sh_iv_low;
  logic [1:0]  sh_key_length;
  logic        sh_decrypt;
  logic [31:0] sh_round_keys [60];
  logic [127:0] sh_chain;
  logic        sh_schedule_ok;

  logic [7:0] sbox_fwd [256];
  logic [7:0] sbox_inv [256];

  cbc_block_t pending_results [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = xtime(a);
      b = b >> 1;
    end
    gf_mul = p;
  endfunction

  // The S-box tables are derived from the field inverse and the affine map.
  initial begin : build_sboxes
    logic [7:0] inv, b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      if (x != 0) begin
        inv = 8'h01;
        for (int e = 0; e < 254; e++) inv = gf_mul(inv, x[7:0]);
      end
      b = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_fwd[x] = b;
      sbox_inv[b] = x[7:0];
    end
  end

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {sbox_fwd[w[31:24]], sbox_fwd[w[23:16]], sbox_fwd[w[15:8]], sbox_fwd[w[7:0]]};
  endfunction

  // Key words in use: 4, 6 or 8. A key length of three saturates to 256 bits.
  function automatic int key_words_used();
    key_words_used = (sh_key_length > 2'd2) ? 8 : 4 + 2 * sh_key_length;
  endfunction

  task automatic expand_schedule();
    logic [31:0] t;
    logic [7:0] rc;
    int nk;
    nk = key_words_used();
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      sh_round_keys[i] = i[0] ? sh_key[(i >> 1) & 3][31:0] : sh_key[(i >> 1) & 3][63:32];
    for (int i = nk; i < 4 * (nk + 7); i++) begin
      t = sh_round_keys[i - 1];
      if (i % nk == 0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = xtime(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_word(t);
      end
      sh_round_keys[i] = sh_round_keys[i - nk] ^ t;
    end
    sh_schedule_ok = 1'b1;
  endtask

  // Byte k of a state lives at bits [127-8k -: 8], as in the block's byte order.
  function automatic logic [127:0] rk_xor(input logic [127:0] s, input int r);
    logic [31:0] w;
    for (int k = 0; k < 16; k++) begin
      w = sh_round_keys[4 * r + k / 4];
      s[127 - 8 * k -: 8] ^= w[31 - 8 * (k % 4) -: 8];
    end
    rk_xor = s;
  endfunction

  function automatic logic [127:0] sbox_apply(input logic [127:0] s, input logic inverse);
    for (int k = 0; k < 16; k++)
      s[127 - 8 * k -: 8] = inverse ? sbox_inv[s[127 - 8 * k -: 8]]
                                    : sbox_fwd[s[127 - 8 * k -: 8]];
    sbox_apply = s;
  endfunction

  function automatic logic [127:0] row_rotate(input logic [127:0] s, input logic inverse);
    logic [127:0] t;
    int src;
    t = s;
    for (int r = 1; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        src = r + 4 * ((inverse ? c + 4 - r : c + r) % 4);
        s[127 - 8 * (r + 4 * c) -: 8] = t[127 - 8 * src -: 8];
      end
    row_rotate = s;
  endfunction

  function automatic logic [127:0] column_mix(input logic [127:0] s, input logic inverse);
    logic [7:0] a0, a1, a2, a3, x;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      if (!inverse) begin
        x = a0 ^ a1 ^ a2 ^ a3;
        s[127 - 32 * c -: 8] = a0 ^ x ^ xtime(a0 ^ a1);
        s[119 - 32 * c -: 8] = a1 ^ x ^ xtime(a1 ^ a2);
        s[111 - 32 * c -: 8] = a2 ^ x ^ xtime(a2 ^ a3);
        s[103 - 32 * c -: 8] = a3 ^ x ^ xtime(a3 ^ a0);
      end else begin
        s[127 - 32 * c -: 8] = gf_mul(a0, 8'h0e) ^ gf_mul(a1, 8'h0b) ^ gf_mul(a2, 8'h0d)
                               ^ gf_mul(a3, 8'h09);
        s[119 - 32 * c -: 8] = gf_mul(a0, 8'h09) ^ gf_mul(a1, 8'h0e) ^ gf_mul(a2, 8'h0b)
                               ^ gf_mul(a3, 8'h0d);
        s[111 - 32 * c -: 8] = gf_mul(a0, 8'h0d) ^ gf_mul(a1, 8'h09) ^ gf_mul(a2, 8'h0e)
                               ^ gf_mul(a3, 8'h0b);
        s[103 - 32 * c -: 8] = gf_mul(a0, 8'h0b) ^ gf_mul(a1, 8'h0d) ^ gf_mul(a2, 8'h09)
                               ^ gf_mul(a3, 8'h0e);
      end
    end
    column_mix = s;
  endfunction

  // Runs one block through the CBC shadow state and returns the block it should produce.
  task automatic cbc_transform(input cbc_block_t blk, output cbc_block_t res);
    logic [127:0] s;
    int nr;
    if (!sh_schedule_ok) expand_schedule();
    nr = key_words_used() + 6;
    if (!sh_decrypt) begin
      s = rk_xor({blk.hi, blk.lo} ^ sh_chain, 0);
      for (int r = 1; r < nr; r++)
        s = rk_xor(column_mix(row_rotate(sbox_apply(s, 1'b0), 1'b0), 1'b0), r);
      s = rk_xor(row_rotate(sbox_apply(s, 1'b0), 1'b0), nr);
      sh_chain = s;
    end else begin
      s = rk_xor({blk.hi, blk.lo}, nr);
      for (int r = nr - 1; r >= 1; r--)
        s = column_mix(rk_xor(sbox_apply(row_rotate(s, 1'b1), 1'b1), r), 1'b1);
      s = rk_xor(sbox_apply(row_rotate(s, 1'b1), 1'b1), 0) ^ sh_chain;
      sh_chain = {blk.hi, blk.lo};
    end
    // The chain starts over from the IV once a message ends.
    if (blk.last) sh_chain = {sh_iv_high, sh_iv_low};
    res = '{hi: s[127:64], lo: s[63:0], last: blk.last};
  endtask

  // Register write, issued only with the block idle: every result has come back first.
  task automatic write_register(input logic [2:0] index, input logic [63:0] value);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    in_valid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      RegKey0, RegKey1, RegKey2, RegKey3: begin
        sh_key[index[1:0]] = value;
        sh_schedule_ok = 1'b0;
      end
      RegIvHigh: sh_iv_high = value;
      RegIvLow: sh_iv_low = value;
      RegKeyLength: begin
        sh_key_length = value[1:0];
        sh_schedule_ok = 1'b0;
      end
      RegDirection: sh_decrypt = value[0];
      default: ;
    endcase
    sh_chain = {sh_iv_high, sh_iv_low};
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offers one block and records its expected result once the transfer happens. Valid is
  // dropped after the transfer so that the same block is never offered twice; a following
  // block that does not idle first raises it again at the same falling edge.
  task automatic send_block(input cbc_block_t blk, input logic has_known,
                            input logic [63:0] known_hi, input logic [63:0] known_lo);
    cbc_block_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    block_high = blk.hi;
    block_low = blk.lo;
    last_block = blk.last;
    do @(posedge clk); while (!in_ready);
    cbc_transform(blk, res);
    if (has_known) begin
      res.hi = known_hi;
      res.lo = known_lo;
    end
    pending_results.push_back(res);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic logic [63:0] random_word();
    case ($urandom_range(15))
      0: random_word = '0;
      1: random_word = '1;
      default: random_word = {$urandom, $urandom};
    endcase
  endfunction

  // Receiver: stalls at random according to the current phase.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Result checker: each transfer on the output is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %h %h last=%b", result_high, result_low, result_last);
      end else begin : compare
        cbc_block_t want;
        want = pending_results.pop_front();
        if (result_high !== want.hi || result_low !== want.lo || result_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h %h last=%b, got %h %h last=%b",
                     want.hi, want.lo, want.last, result_high, result_low, result_last);
        end
      end
    end
  end

  // Watchdog: counts cycles without any transfer on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("[aes_cbc_cipher] ERROR");
      $finish;
    end
  end

  // Directed part: published AES vectors where the result is known, plus extremes and
  // chaining cases checked by the predictor.
  localparam int DirectedRows = 24;
  localparam stim_row_t Directed [DirectedRows] = '{
    // Right after reset: all-zero key and IV.
    '{ROW_BLOCK, 3'd0, 64'h0, 64'h0, 1'b1, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
    '{ROW_CFG, RegKey0, 64'h0001020304050607, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, RegKey1, 64'h08090a0b0c0d0e0f, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, 3'd0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b1,
      64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
    '{ROW_BLOCK, 3'd0, '1, '1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, 3'd0, '1, '1, 1'b1, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, RegKey2, 64'h1011121314151617, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, RegKeyLength, 64'h1, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, 3'd0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b1,
      64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191},
    '{ROW_CFG, RegKey3, 64'h18191a1b1c1d1e1f, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, RegKeyLength, 64'h2, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, 3'd0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b1,
      64'h8ea2b7ca516745bf, 64'heafc49904b496089},
    // Key length three saturates to a 256-bit key.
    '{ROW_CFG, RegKeyLength, 64'h3, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, 3'd0, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b1,
      64'h8ea2b7ca516745bf, 64'heafc49904b496089},
    '{ROW_CFG, RegDirection, 64'h1, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, 3'd0, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1, 1'b1,
      64'h0011223344556677, 64'h8899aabbccddeeff},
    '{ROW_CFG, RegIvHigh, '1, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, RegIvLow, '1, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, 3'd0, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, 3'd0, '1, '1, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, 3'd0, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, RegKeyLength, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_CFG, RegDirection, 64'h0, 64'h0, 1'b0, 1'b0, 64'h0, 64'h0},
    '{ROW_BLOCK, 3'd0, 64'h0, '1, 1'b0, 1'b0, 64'h0, 64'h0}
  };

  initial begin : stimulus
    cbc_block_t blk;
    int unsigned msg_left;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    block_high = '0;
    block_low = '0;
    last_block = 1'b0;
    out_ready = 1'b0;
    mismatches = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 4; i++) sh_key[i] = '0;
    sh_iv_high = '0;
    sh_iv_low = '0;
    sh_key_length = '0;
    sh_decrypt = 1'b0;
    sh_chain = '0;
    sh_schedule_ok = 1'b0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    foreach (Directed[i]) begin
      if (Directed[i].kind == ROW_CFG)
        write_register(Directed[i].index, Directed[i].hi);
      else
        send_block('{hi: Directed[i].hi, lo: Directed[i].lo, last: Directed[i].last},
                   Directed[i].has_known, Directed[i].known_hi, Directed[i].known_lo);
    end

    // Random part: four phases with their own sender idle and receiver stall rates,
    // each from a fresh random configuration, sending CBC messages of one to eight blocks.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 28 : 54) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 28 : 54) : 0;
      msg_left = 0;
      for (int n = 0; n < RandomBlocksPerPhase; n++) begin
        if (n % 150 == 0) begin
          for (int r = 0; r < 8; r++)
            if (n == 0 || $urandom_range(2) == 0) write_register(r[2:0], random_word());
        end
        // Hold off the sender once until the block has drained completely.
        if (n == 200) while (pending_results.size() != 0) begin
          in_valid = 1'b0;
          @(negedge clk);
        end
        if (msg_left == 0) msg_left = $urandom_range(8, 1);
        msg_left--;
        blk = '{hi: random_word(), lo: random_word(), last: (msg_left == 0)};
        send_block(blk, 1'b0, 64'h0, 64'h0);
      end
    end
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("[aes_cbc_cipher] OK");
    else
      $display("[aes_cbc_cipher] ERROR");
    $finish;
  end

endmodule
